@@ design/sbq_pkg.sv @@
// shared types and constants for the semaphore blocked queue table
`timescale 1ns / 1ps

package sbq_pkg;

	localparam int CMD_W       = 2;
	localparam int SEM_KEY_W   = 32;
	localparam int PROC_ID_W   = 4;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 8;

	localparam int DEF_NUM_DESCRIPTORS = 16;
	localparam int DEF_NUM_PROCS       = 16;
	localparam int DEF_KEY_WIDTH       = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_UNLINK = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_BLOCKED = 2'd3
	} status_t;

	// classified command as it waits between front and back
	typedef struct packed {
		cmd_t                 cmd;
		logic [SEM_KEY_W-1:0] sem_key;
		logic [PROC_ID_W-1:0] proc_id;
		logic                 proc_ok;
	} item_t;

endpackage

@@ design/sbq_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sbq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/sbq_front.sv @@
// input side: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps

module sbq_front #(
	parameter int NUM_PROCS = sbq_pkg::DEF_NUM_PROCS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sbq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [sbq_pkg::CMD_W-1:0]     s_tuser,
	output sbq_pkg::item_t                item,
	output logic                          item_valid,
	input  logic                          item_pop
);

	localparam int QDEPTH = 2;

	sbq_pkg::item_t q_item_q [QDEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	sbq_pkg::item_t in_item;
	logic           push;

	always_comb begin
		in_item.cmd     = sbq_pkg::cmd_t'(s_tuser);
		in_item.sem_key = s_tdata[sbq_pkg::SEM_KEY_W-1:0];
		in_item.proc_id = s_tdata[sbq_pkg::SEM_KEY_W +: sbq_pkg::PROC_ID_W];
		// process index beyond the table is flagged here once
		in_item.proc_ok = 32'(in_item.proc_id) < NUM_PROCS;
	end

	assign s_tready   = count_q != 2'(QDEPTH);
	assign push       = s_tvalid && s_tready;
	assign item_valid = count_q != 2'd0;
	assign item       = q_item_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && item_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_item_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

@@ design/sbq_back.sv @@
// back end: key lookup, queue pointer update and result register
`timescale 1ns / 1ps

module sbq_back #(
	parameter int NUM_DESCRIPTORS = sbq_pkg::DEF_NUM_DESCRIPTORS,
	parameter int NUM_PROCS       = sbq_pkg::DEF_NUM_PROCS,
	parameter int KEY_WIDTH       = sbq_pkg::DEF_KEY_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbq_pkg::item_t                item,
	input  logic                          item_valid,
	output logic                          item_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sbq_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [sbq_pkg::STATUS_W-1:0]  m_tuser
);

	localparam int ND     = NUM_DESCRIPTORS;
	localparam int DW     = ND > 1 ? $clog2(ND) : 1;
	localparam int NP_MAX = 2 ** sbq_pkg::PROC_ID_W;
	localparam int NP     = NUM_PROCS < NP_MAX ? NUM_PROCS : NP_MAX;
	localparam int PW     = NP > 1 ? $clog2(NP) : 1;
	localparam int KW     = KEY_WIDTH < sbq_pkg::SEM_KEY_W ? KEY_WIDTH : sbq_pkg::SEM_KEY_W;

	typedef enum logic {S_LOOK, S_EXEC} state_t;

	// descriptor side
	logic          desc_valid_q [ND];
	logic [KW-1:0] desc_key_q   [ND];
	// process side
	logic [PW-1:0] proc_next_q    [NP];
	logic [PW-1:0] proc_prev_q    [NP];
	logic          proc_blocked_q [NP];
	logic [DW-1:0] proc_desc_q    [NP];

	state_t              state_q;
	logic                out_valid_q;
	sbq_pkg::status_t    status_q;
	logic [sbq_pkg::PROC_ID_W-1:0] res_q;

	sbq_pkg::cmd_t cmd_s1;
	logic [KW-1:0] key_s1;
	logic [PW-1:0] p_s1;
	logic          pok_s1;
	logic          blk_s1;
	logic          hit_s1;
	logic          has_free_s1;
	logic          dval_s1;
	logic [DW-1:0] d_s1;
	logic [DW-1:0] dfree_s1;

	// lookup stage
	logic          look_fire;
	logic          hit;
	logic          has_free;
	logic [DW-1:0] d_hit;
	logic [DW-1:0] d_free;
	logic [PW-1:0] p_idx;
	logic          blk;
	logic [DW-1:0] pd;
	logic [DW-1:0] d_sel;

	// execute stage
	logic          exec_fire;
	logic [PW-1:0] head;
	logic [PW-1:0] tail;
	logic [PW-1:0] tg;
	logic [PW-1:0] nx;
	logic [PW-1:0] pv;
	logic          is_head;
	logic          is_tail;
	logic          ins_ok;
	logic          ins_new;
	logic          unl_ok;
	logic          both;
	sbq_pkg::status_t st;
	logic [sbq_pkg::PROC_ID_W-1:0] res;
	logic          head_we;
	logic          tail_we;
	logic [DW-1:0] wr_d;
	logic [PW-1:0] head_wdata;
	logic [PW-1:0] tail_wdata;

	assign look_fire = (state_q == S_LOOK) && item_valid;
	assign item_pop  = look_fire;
	assign p_idx     = item.proc_id[PW-1:0];

	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		d_hit    = '0;
		d_free   = '0;
		// scan downward so the lowest index wins
		for (int i = ND - 1; i >= 0; i--) begin
			if (desc_valid_q[i] && desc_key_q[i] == item.sem_key[KW-1:0]) begin
				hit   = 1'b1;
				d_hit = DW'(i);
			end
			if (!desc_valid_q[i]) begin
				has_free = 1'b1;
				d_free   = DW'(i);
			end
		end
	end

	assign blk   = item.proc_ok && proc_blocked_q[p_idx];
	assign pd    = proc_desc_q[p_idx];
	assign d_sel = (item.cmd == sbq_pkg::CMD_UNLINK) ? pd : d_hit;

	sbq_ram #(.WIDTH(PW), .DEPTH(ND)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (wr_d),
		.wdata (head_wdata),
		.re    (look_fire),
		.raddr (d_sel),
		.rdata (head)
	);

	sbq_ram #(.WIDTH(PW), .DEPTH(ND)) u_tail_ram (
		.clk   (clk),
		.we    (tail_we),
		.waddr (wr_d),
		.wdata (tail_wdata),
		.re    (look_fire),
		.raddr (d_sel),
		.rdata (tail)
	);

	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	always_comb begin
		tg      = (cmd_s1 == sbq_pkg::CMD_REMOVE) ? head : p_s1;
		nx      = proc_next_q[tg];
		pv      = proc_prev_q[tg];
		is_head = head == tg;
		is_tail = tail == tg;
		both    = is_head && is_tail;
		ins_ok  = (cmd_s1 == sbq_pkg::CMD_INSERT) && pok_s1 && !blk_s1 && (hit_s1 || has_free_s1);
		ins_new = ins_ok && !hit_s1;
		unl_ok  = ((cmd_s1 == sbq_pkg::CMD_REMOVE) && hit_s1) ||
		          ((cmd_s1 == sbq_pkg::CMD_UNLINK) && pok_s1 && blk_s1 && dval_s1);

		st  = sbq_pkg::ST_ABSENT;
		res = '0;
		case (cmd_s1)
			sbq_pkg::CMD_INSERT: begin
				if (!pok_s1) begin
					st = sbq_pkg::ST_ABSENT;
				end else if (blk_s1) begin
					st = sbq_pkg::ST_BLOCKED;
				end else if (hit_s1 || has_free_s1) begin
					st = sbq_pkg::ST_OK;
				end else begin
					st = sbq_pkg::ST_FULL;
				end
			end
			sbq_pkg::CMD_REMOVE, sbq_pkg::CMD_PEEK: begin
				if (hit_s1) begin
					st  = sbq_pkg::ST_OK;
					res = sbq_pkg::PROC_ID_W'(head);
				end
			end
			sbq_pkg::CMD_UNLINK: begin
				if (unl_ok) begin
					st  = sbq_pkg::ST_OK;
					res = sbq_pkg::PROC_ID_W'(p_s1);
				end
			end
			default: begin
				st = sbq_pkg::ST_ABSENT;
			end
		endcase

		wr_d       = ins_new ? dfree_s1 : d_s1;
		head_we    = exec_fire && (ins_new || (unl_ok && !both && is_head));
		head_wdata = ins_new ? p_s1 : nx;
		tail_we    = exec_fire && (ins_ok || (unl_ok && !both && is_tail));
		tail_wdata = ins_ok ? p_s1 : pv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOOK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !exec_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOOK: begin
					if (look_fire) begin
						cmd_s1      <= item.cmd;
						key_s1      <= item.sem_key[KW-1:0];
						p_s1        <= p_idx;
						pok_s1      <= item.proc_ok;
						blk_s1      <= blk;
						hit_s1      <= hit;
						has_free_s1 <= has_free;
						dval_s1     <= desc_valid_q[pd];
						d_s1        <= d_sel;
						dfree_s1    <= d_free;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						out_valid_q <= 1'b1;
						status_q    <= st;
						res_q       <= res;
						state_q     <= S_LOOK;
					end
				end
				default: begin
					state_q <= S_LOOK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ND; i++) begin
				desc_valid_q[i] <= 1'b0;
			end
			for (int i = 0; i < NP; i++) begin
				proc_blocked_q[i] <= 1'b0;
			end
		end else if (exec_fire) begin
			if (ins_new) begin
				desc_valid_q[dfree_s1] <= 1'b1;
			end
			if (unl_ok && both) begin
				desc_valid_q[d_s1] <= 1'b0;
			end
			if (ins_ok) begin
				proc_blocked_q[p_s1] <= 1'b1;
			end
			if (unl_ok) begin
				proc_blocked_q[tg] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			if (ins_new) begin
				desc_key_q[dfree_s1] <= key_s1;
			end
			if (ins_ok) begin
				// append behind the current tail when the key is already active
				if (hit_s1) begin
					proc_next_q[tail] <= p_s1;
					proc_prev_q[p_s1] <= tail;
				end
				proc_next_q[p_s1] <= '0;
				proc_desc_q[p_s1] <= ins_new ? dfree_s1 : d_s1;
			end
			if (unl_ok && !both) begin
				if (!is_head) begin
					proc_next_q[pv] <= nx;
				end
				if (!is_tail) begin
					proc_prev_q[nx] <= pv;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sbq_pkg::M_TDATA_W'(res_q);
	assign m_tuser  = status_q;

endmodule

@@ design/semaphore_blocked_queue_table_top.sv @@
// Table of active semaphores with a FIFO of blocked processes per key.
//
// Input channel s_*: one command per item. s_tuser carries the command
// (insert, remove head, unlink process, peek head); s_tdata carries the
// semaphore key and the process index. Output channel m_*: exactly one
// result per command, in order. m_tuser carries the status, m_tdata the
// process removed, unlinked or peeked (zero unless status is ok).
//
// A front end classifies items into a two entry queue; the back end runs
// each item in two steps: an associative key compare over the descriptor
// keys with a read of the head/tail ram, then the pointer update and the
// result register load. The back end takes no new item from the queue until
// the update of the last one is done, and the update waits while a held
// result is not taken.
//
// Reset clears every descriptor and every blocked flag at once; no clearing
// pass is needed. While m_tready is low one result is held, the back end
// waits, and the front queue keeps taking items until it holds two.
`timescale 1ns / 1ps

module semaphore_blocked_queue_table_top #(
	parameter int NUM_DESCRIPTORS = sbq_pkg::DEF_NUM_DESCRIPTORS,
	parameter int NUM_PROCS       = sbq_pkg::DEF_NUM_PROCS,
	parameter int KEY_WIDTH       = sbq_pkg::DEF_KEY_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sbq_pkg::S_TDATA_W-1:0] s_tdata,  // sem_key[31:0], proc_id[35:32], zero pad
	input  logic [sbq_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sbq_pkg::M_TDATA_W-1:0] m_tdata,  // result_proc[3:0], zero pad
	output logic [sbq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);

	sbq_pkg::item_t item;
	logic           item_valid;
	logic           item_pop;

	sbq_front #(.NUM_PROCS(NUM_PROCS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	sbq_back #(
		.NUM_DESCRIPTORS (NUM_DESCRIPTORS),
		.NUM_PROCS       (NUM_PROCS),
		.KEY_WIDTH       (KEY_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
